@@ hdl/ictag_pkg.sv @@
// Shared definitions for the instruction cache tag lookup block.
// Holds parameter defaults, register indexes, reset values and the FSM type.
// No dependencies.
package ictag_pkg;

    localparam int SETS_DEF             = 256;
    localparam int WAYS_DEF             = 4;
    localparam int LINE_OFFSET_BITS_DEF = 4;

    localparam int ADDR_W    = 32;
    localparam int DELAY_W   = 8;
    localparam int LFSR_W    = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_BASE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LIMIT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HIT_DELAY      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_DELAY     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNCACHED_DELAY = 3'd4;

    localparam logic [ADDR_W-1:0]  WINDOW_BASE_RST    = 32'h8000_0000;
    localparam logic [ADDR_W-1:0]  WINDOW_LIMIT_RST   = 32'hC000_0000;
    localparam logic [DELAY_W-1:0] HIT_DELAY_RST      = 8'd1;
    localparam logic [DELAY_W-1:0] FILL_DELAY_RST     = 8'd6;
    localparam logic [DELAY_W-1:0] UNCACHED_DELAY_RST = 8'd5;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } t_state;

endpackage

@@ hdl/ictag_ram.sv @@
// Tag RAM: one write port, one read port, registered read data.
// Depends on nothing; sized by its parameters.
module ictag_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 84
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/icache_tag_lookup_random_replace_top.sv @@
// Top level of the set-associative instruction cache tag lookup.
// Depends on ictag_pkg and ictag_ram.
//
// The set row of each fetch address is read from the tag RAM in the accept cycle and
// compared in the next one; a row that needs a fill is written back once the result
// register is free, so the single read-modify-write of the tag RAM means a new address
// is taken only after the previous lookup has finished. The result is registered and
// appears the cycle after the lookup; a new address is taken while a result still waits.
// After reset a clearing pass writes every set row invalid, one row per cycle; no
// address is taken during it, while configuration writes are taken at any time.
module icache_tag_lookup_random_replace_top #(
    parameter int SETS             = ictag_pkg::SETS_DEF,
    parameter int WAYS             = ictag_pkg::WAYS_DEF,
    parameter int LINE_OFFSET_BITS = ictag_pkg::LINE_OFFSET_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [ictag_pkg::ADDR_W-1:0]    i_fetch_address,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_is_miss,
    output logic [ictag_pkg::DELAY_W-1:0]   o_delay_cycles,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ictag_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ictag_pkg::CFG_DAT_W-1:0] i_cfg_data
);

    localparam int IB      = $clog2(SETS);
    localparam int TAG_W   = ictag_pkg::ADDR_W - LINE_OFFSET_BITS - IB;
    localparam int WAY_W   = $clog2(WAYS);
    localparam int ENTRY_W = TAG_W + 1;
    localparam int ROW_W   = WAYS * ENTRY_W;
    localparam int LUT_N   = 1 << ictag_pkg::LFSR_W;

    typedef struct packed {
        logic             valid;
        logic [TAG_W-1:0] tag;
    } t_way;

    ictag_pkg::t_state r_state, n_state;

    // configuration
    logic [ictag_pkg::ADDR_W-1:0]  r_base, r_limit;
    logic [ictag_pkg::DELAY_W-1:0] r_hit_dly, r_fill_dly, r_unc_dly;

    logic [IB-1:0]                 r_clr_idx;
    logic [IB-1:0]                 r_set;
    logic [TAG_W-1:0]              r_tag;
    logic                          r_cacheable;
    logic [ictag_pkg::LFSR_W-1:0]  r_lfsr;
    logic                          r_out_valid;
    logic                          r_is_miss;
    logic [ictag_pkg::DELAY_W-1:0] r_delay;

    logic             w_accept;
    logic             w_done;
    logic [IB:0]      w_set_ext;
    logic [IB-1:0]    w_set;
    logic             w_in_window;
    logic             w_mem_we;
    logic [IB-1:0]    w_mem_waddr;
    logic [ROW_W-1:0] w_mem_wdata;
    logic [ROW_W-1:0] w_mem_rdata;

    t_way [WAYS-1:0]  w_row, w_new_row;
    logic             w_hit;
    logic             w_found_inv;
    logic [WAY_W-1:0] w_inv_way;
    logic [WAY_W-1:0] w_way;
    logic             w_fill;
    logic [ictag_pkg::LFSR_W-1:0] w_lfsr_next;
    logic [WAY_W-1:0] w_victim_lut [LUT_N];

    // LFSR value to way number
    for (genvar k = 0; k < LUT_N; k++) begin : g_lut
        assign w_victim_lut[k] = WAY_W'(k % WAYS);
    end

    // ------------------------------------------------------------------ FSM
    always_comb begin
        n_state = r_state;
        case (r_state)
            ictag_pkg::ST_CLEAR: begin
                if (r_clr_idx == IB'(SETS - 1)) begin
                    n_state = ictag_pkg::ST_IDLE;
                end
            end
            ictag_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ictag_pkg::ST_LOOKUP;
                end
            end
            ictag_pkg::ST_LOOKUP: begin
                if (w_done) begin
                    n_state = ictag_pkg::ST_IDLE;
                end
            end
            default: n_state = ictag_pkg::ST_CLEAR;
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        w_mem_we    = 1'b0;
        w_mem_waddr = r_set;
        w_mem_wdata = w_new_row;
        w_done      = 1'b0;
        case (r_state)
            ictag_pkg::ST_CLEAR: begin
                w_mem_we    = 1'b1;
                w_mem_waddr = r_clr_idx;
                w_mem_wdata = '0;
            end
            ictag_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
            end
            ictag_pkg::ST_LOOKUP: begin
                w_done   = !r_out_valid || i_out_ready;
                w_mem_we = w_done && w_fill;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    assign w_accept = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ictag_pkg::ST_CLEAR;
            r_clr_idx <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ictag_pkg::ST_CLEAR) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
        end
    end

    // ------------------------------------------------------- configuration
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base     <= ictag_pkg::WINDOW_BASE_RST;
            r_limit    <= ictag_pkg::WINDOW_LIMIT_RST;
            r_hit_dly  <= ictag_pkg::HIT_DELAY_RST;
            r_fill_dly <= ictag_pkg::FILL_DELAY_RST;
            r_unc_dly  <= ictag_pkg::UNCACHED_DELAY_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ictag_pkg::CFG_WINDOW_BASE:    r_base     <= i_cfg_data;
                ictag_pkg::CFG_WINDOW_LIMIT:   r_limit    <= i_cfg_data;
                ictag_pkg::CFG_HIT_DELAY:      r_hit_dly  <= i_cfg_data[7:0];
                ictag_pkg::CFG_FILL_DELAY:     r_fill_dly <= i_cfg_data[7:0];
                ictag_pkg::CFG_UNCACHED_DELAY: r_unc_dly  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------- address split
    always_comb begin
        w_set_ext = {1'b0, i_fetch_address[LINE_OFFSET_BITS +: IB]};
        w_set     = w_set_ext[IB-1:0];
        // only reachable when SETS is not a power of two
        if (w_set_ext >= (IB + 1)'(SETS)) begin
            w_set = w_set_ext[IB-1:0] - IB'(SETS);
        end
    end

    assign w_in_window = (r_base <= i_fetch_address) && (i_fetch_address < r_limit);

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_set       <= w_set;
            r_tag       <= i_fetch_address[ictag_pkg::ADDR_W-1 -: TAG_W];
            r_cacheable <= w_in_window;
        end
    end

    ictag_ram #(
        .DEPTH (SETS),
        .WIDTH (ROW_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_accept),
        .i_raddr (w_set),
        .o_rdata (w_mem_rdata)
    );

    // ------------------------------------------------------ compare and fill
    assign w_lfsr_next = {r_lfsr[6:0], ~(r_lfsr[7] ^ r_lfsr[3] ^ r_lfsr[2] ^ r_lfsr[1])};

    always_comb begin
        w_row       = w_mem_rdata;
        w_hit       = 1'b0;
        w_found_inv = 1'b0;
        w_inv_way   = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (w_row[w].valid && (w_row[w].tag == r_tag)) begin
                w_hit = 1'b1;
            end
            if (!w_row[w].valid) begin
                w_found_inv = 1'b1;
                w_inv_way   = WAY_W'(w);
            end
        end
        w_way = w_found_inv ? w_inv_way : w_victim_lut[w_lfsr_next];
        w_new_row        = w_row;
        w_new_row[w_way] = '{valid: 1'b1, tag: r_tag};
        w_fill           = r_cacheable && !w_hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr <= '0;
        end else if (w_mem_we && (r_state == ictag_pkg::ST_LOOKUP) && !w_found_inv) begin
            r_lfsr <= w_lfsr_next;
        end
    end

    // --------------------------------------------------------------- result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_is_miss <= !(r_cacheable && w_hit);
            if (!r_cacheable) begin
                r_delay <= r_unc_dly;
            end else if (w_hit) begin
                r_delay <= r_hit_dly;
            end else begin
                r_delay <= r_fill_dly;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_is_miss      = r_is_miss;
    assign o_delay_cycles = r_delay;

endmodule

@@ verif/ictag_checker.sv @@
// Scoreboard for the instruction cache tag lookup: watches the fetch, result and
// register write channels, keeps a shadow tag store and replacement LFSR, and checks results.
// Depends on ictag_pkg.
module ictag_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic [ictag_pkg::ADDR_W-1:0]    i_fetch_address,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic                            i_is_miss,
    input  logic [ictag_pkg::DELAY_W-1:0]   i_delay_cycles,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [ictag_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ictag_pkg::CFG_DAT_W-1:0] i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending
);

    localparam int NSETS = ictag_pkg::SETS_DEF;
    localparam int NWAYS = ictag_pkg::WAYS_DEF;
    localparam int OFF_W = ictag_pkg::LINE_OFFSET_BITS_DEF;
    localparam int IDX_W = $clog2(ictag_pkg::SETS_DEF);
    localparam int TAG_W = ictag_pkg::ADDR_W - OFF_W - IDX_W;

    typedef struct packed {
        logic                          is_miss;
        logic [ictag_pkg::DELAY_W-1:0] delay;
    } t_lookup_result;

    logic [ictag_pkg::ADDR_W-1:0]  win_base;
    logic [ictag_pkg::ADDR_W-1:0]  win_limit;
    logic [ictag_pkg::DELAY_W-1:0] hit_dly;
    logic [ictag_pkg::DELAY_W-1:0] fill_dly;
    logic [ictag_pkg::DELAY_W-1:0] uncached_dly;

    logic [TAG_W-1:0]             tag_mem   [0:NSETS-1][0:NWAYS-1];
    logic                         way_valid [0:NSETS-1][0:NWAYS-1];
    logic [ictag_pkg::LFSR_W-1:0] victim_lfsr;

    t_lookup_result results_due[$];
    t_lookup_result want;
    int fails = 0;

    // Updates the shadow tag store as the block would and returns the outcome.
    function automatic t_lookup_result lookup_outcome(
        input logic [ictag_pkg::ADDR_W-1:0] addr);
        logic [IDX_W-1:0] set_idx;
        logic [TAG_W-1:0] tag;
        int               victim;
        t_lookup_result   res;
        if (!(addr >= win_base && addr < win_limit)) begin
            res.is_miss = 1'b1;
            res.delay   = uncached_dly;
            return res;
        end
        set_idx = addr[OFF_W +: IDX_W];
        tag     = addr[ictag_pkg::ADDR_W-1 -: TAG_W];
        for (int w = 0; w < NWAYS; w++) begin
            if (way_valid[set_idx][w] && tag_mem[set_idx][w] == tag) begin
                res.is_miss = 1'b0;
                res.delay   = hit_dly;
                return res;
            end
        end
        victim = -1;
        for (int w = 0; w < NWAYS; w++) begin
            if (!way_valid[set_idx][w] && victim < 0)
                victim = w;
        end
        // LFSR steps only when the whole set is valid
        if (victim < 0) begin
            victim_lfsr = {victim_lfsr[6:0],
                           ~(victim_lfsr[7] ^ victim_lfsr[3] ^ victim_lfsr[2] ^ victim_lfsr[1])};
            victim = int'(victim_lfsr) % NWAYS;
        end
        tag_mem[set_idx][victim]   = tag;
        way_valid[set_idx][victim] = 1'b1;
        res.is_miss = 1'b1;
        res.delay   = fill_dly;
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            win_base     = ictag_pkg::WINDOW_BASE_RST;
            win_limit    = ictag_pkg::WINDOW_LIMIT_RST;
            hit_dly      = ictag_pkg::HIT_DELAY_RST;
            fill_dly     = ictag_pkg::FILL_DELAY_RST;
            uncached_dly = ictag_pkg::UNCACHED_DELAY_RST;
            victim_lfsr  = '0;
            for (int s = 0; s < NSETS; s++) begin
                for (int w = 0; w < NWAYS; w++) begin
                    tag_mem[s][w]   = '0;
                    way_valid[s][w] = 1'b0;
                end
            end
            results_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    ictag_pkg::CFG_WINDOW_BASE:    win_base     = i_cfg_data;
                    ictag_pkg::CFG_WINDOW_LIMIT:   win_limit    = i_cfg_data;
                    ictag_pkg::CFG_HIT_DELAY:
                        hit_dly      = i_cfg_data[ictag_pkg::DELAY_W-1:0];
                    ictag_pkg::CFG_FILL_DELAY:
                        fill_dly     = i_cfg_data[ictag_pkg::DELAY_W-1:0];
                    ictag_pkg::CFG_UNCACHED_DELAY:
                        uncached_dly = i_cfg_data[ictag_pkg::DELAY_W-1:0];
                    default: ;
                endcase
            end
            // results pop before the new fetch is pushed: a result is never for
            // a transaction accepted at the same edge
            if (i_out_valid && i_out_ready) begin
                if (results_due.size() == 0) begin
                    $error("unexpected result: is_miss %0d, delay_cycles %0d",
                           i_is_miss, i_delay_cycles);
                    fails++;
                end else begin
                    want = results_due.pop_front();
                    if (i_is_miss !== want.is_miss) begin
                        $error("is_miss: expected %0d, actual %0d", want.is_miss, i_is_miss);
                        fails++;
                    end
                    if (i_delay_cycles !== want.delay) begin
                        $error("delay_cycles: expected %0d, actual %0d",
                               want.delay, i_delay_cycles);
                        fails++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                results_due.push_back(lookup_outcome(i_fetch_address));
        end
        o_pending    <= results_due.size();
        o_fail_count <= fails;
    end

endmodule

@@ verif/tb.sv @@
// Testbench top for the instruction cache tag lookup: clock, reset, fetch and register
// stimulus with random stalls, watchdog and verdict.
// Depends on ictag_pkg, icache_tag_lookup_random_replace_top and ictag_checker.
module tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASES         = 6;
    localparam int PHASE_ITEMS    = 175;

    // indexes past the register list; writes to them must be dropped
    localparam logic [ictag_pkg::CFG_IDX_W-1:0] CFG_SPARE_5 = 3'd5;
    localparam logic [ictag_pkg::CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [ictag_pkg::CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

    logic                            i_clk           = 1'b0;
    logic                            i_rst_n         = 1'b0;
    logic                            i_in_valid      = 1'b0;
    logic [ictag_pkg::ADDR_W-1:0]    i_fetch_address = '0;
    logic                            i_out_ready     = 1'b0;
    logic                            i_cfg_valid     = 1'b0;
    logic [ictag_pkg::CFG_IDX_W-1:0] i_cfg_index     = '0;
    logic [ictag_pkg::CFG_DAT_W-1:0] i_cfg_data      = '0;

    logic                            o_in_ready;
    logic                            o_out_valid;
    logic                            o_is_miss;
    logic [ictag_pkg::DELAY_W-1:0]   o_delay_cycles;
    logic                            o_cfg_ready;

    int fail_count;
    int pending;
    int quiet_cycles = 0;
    bit quiet = 1'b0;

    logic [ictag_pkg::ADDR_W-1:0] cur_base  = ictag_pkg::WINDOW_BASE_RST;
    logic [ictag_pkg::ADDR_W-1:0] cur_limit = ictag_pkg::WINDOW_LIMIT_RST;
    logic [19:0]                  tag_pool [0:7];
    logic [7:0]                   set_pool [0:3];

    icache_tag_lookup_random_replace_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_fetch_address (i_fetch_address),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_is_miss       (o_is_miss),
        .o_delay_cycles  (o_delay_cycles),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    ictag_checker chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_fetch_address (i_fetch_address),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_is_miss       (o_is_miss),
        .i_delay_cycles  (o_delay_cycles),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // result side back-pressure in bursts
    initial begin
        forever begin
            @(posedge i_clk);
            if (!quiet && $urandom_range(0, 11) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    task automatic send_fetch(input logic [ictag_pkg::ADDR_W-1:0] addr);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 9) == 0)
            gap = $urandom_range(1, 16);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_fetch_address <= addr;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [ictag_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ictag_pkg::CFG_DAT_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    // drains every transaction in flight before writing the registers
    task automatic program_regs(input logic [ictag_pkg::ADDR_W-1:0] base,
                                input logic [ictag_pkg::ADDR_W-1:0] limit,
                                input logic [ictag_pkg::DELAY_W-1:0] hit,
                                input logic [ictag_pkg::DELAY_W-1:0] fill,
                                input logic [ictag_pkg::DELAY_W-1:0] unc,
                                input logic [ictag_pkg::CFG_IDX_W-1:0] spare_idx);
        wait_drained();
        cfg_write(ictag_pkg::CFG_WINDOW_BASE, base);
        cfg_write(ictag_pkg::CFG_WINDOW_LIMIT, limit);
        // upper data bits of the delay registers are don't-care
        cfg_write(ictag_pkg::CFG_HIT_DELAY, {24'($urandom_range(0, 16777215)), hit});
        cfg_write(ictag_pkg::CFG_FILL_DELAY, {24'($urandom_range(0, 16777215)), fill});
        cfg_write(ictag_pkg::CFG_UNCACHED_DELAY, {24'($urandom_range(0, 16777215)), unc});
        cfg_write(spare_idx, $urandom);
        i_cfg_valid <= 1'b0;
        cur_base  = base;
        cur_limit = limit;
    endtask

    function automatic logic [ictag_pkg::ADDR_W-1:0] pick_in_window();
        if (cur_base >= cur_limit)
            return $urandom;
        return cur_base + ($urandom % (cur_limit - cur_base));
    endfunction

    function automatic logic [ictag_pkg::ADDR_W-1:0] pick_fetch();
        int r;
        logic [ictag_pkg::ADDR_W-1:0] a;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            a = {tag_pool[$urandom_range(0, 7)], set_pool[$urandom_range(0, 3)],
                 4'($urandom_range(0, 15))};
        end else if (r < 80) begin
            a = $urandom;
        end else if (r < 90) begin
            case ($urandom_range(0, 3))
                0:       a = cur_base;
                1:       a = cur_base - 1;
                2:       a = cur_limit - 1;
                default: a = cur_limit;
            endcase
        end else begin
            a = pick_in_window();
        end
        return a;
    endfunction

    initial begin
        logic [ictag_pkg::ADDR_W-1:0] a0;
        logic [ictag_pkg::ADDR_W-1:0] a1;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // default window: edges, hit after fill, then overfill set 0 to force replacement
        send_fetch(32'h0000_0000);
        send_fetch(32'hFFFF_FFFF);
        send_fetch(32'h7FFF_FFFF);
        send_fetch(32'hC000_0000);
        send_fetch(32'h8000_0000);
        send_fetch(32'h8000_0000);
        send_fetch(32'h8000_000F);
        send_fetch(32'hBFFF_FFFF);
        send_fetch(32'h8000_1000);
        send_fetch(32'h8000_2000);
        send_fetch(32'h8000_3000);
        send_fetch(32'h8000_4000);
        send_fetch(32'h8000_5000);
        send_fetch(32'h8000_6000);
        send_fetch(32'h8000_0000);
        send_fetch(32'h8000_1000);

        // full window: zero tag must miss on set 0xFF, where only one way has been filled
        program_regs(32'h0000_0000, 32'hFFFF_FFFF, 8'd0, 8'd255, 8'd0, CFG_SPARE_7);
        send_fetch(32'h0000_0FF0);
        send_fetch(32'h0000_0FF0);
        send_fetch(32'hFFFF_FFFE);
        send_fetch(32'hFFFF_FFFF);

        // empty windows
        program_regs(32'h4000_0000, 32'h4000_0000, 8'd255, 8'd0, 8'd255, CFG_SPARE_5);
        send_fetch(32'h4000_0000);
        send_fetch(32'h3FFF_FFFF);
        program_regs(32'hFFFF_FFFF, 32'h0000_0000, 8'd1, 8'd6, 8'd5, CFG_SPARE_6);
        send_fetch(32'h8000_0000);

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: program_regs(ictag_pkg::WINDOW_BASE_RST, ictag_pkg::WINDOW_LIMIT_RST,
                                8'($urandom), 8'($urandom), 8'($urandom), CFG_SPARE_5);
                1: program_regs(32'h0000_0000, 32'hFFFF_FFFF, 8'd255, 8'd0, 8'd255,
                                CFG_SPARE_6);
                2: program_regs($urandom, $urandom, 8'($urandom), 8'($urandom),
                                8'($urandom), CFG_SPARE_7);
                3: begin
                    a0 = $urandom;
                    a1 = $urandom;
                    if (a0 < a1)
                        program_regs(a1, a0, 8'd0, 8'd0, 8'd0, CFG_SPARE_5);
                    else
                        program_regs(a0, a1, 8'd0, 8'd0, 8'd0, CFG_SPARE_5);
                end
                4: begin
                    a0 = $urandom & 32'hFFFF_0000;
                    program_regs(a0, a0 + 32'h0004_0000, 8'($urandom), 8'($urandom),
                                 8'($urandom), CFG_SPARE_6);
                end
                default: begin
                    program_regs(32'h0000_0000, 32'h0010_0000, 8'd255, 8'd255, 8'd255,
                                 CFG_SPARE_7);
                    quiet = 1'b1;
                end
            endcase
            for (int k = 0; k < 8; k++)
                tag_pool[k] = 20'(pick_in_window() >> 12);
            for (int k = 0; k < 4; k++)
                set_pool[k] = 8'($urandom);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (!quiet && (i == 60 || $urandom_range(0, 199) == 0))
                    wait_drained();
                send_fetch(pick_fetch());
            end
        end

        wait_drained();
        repeat (16) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/ictag_pkg.sv
hdl/ictag_ram.sv
hdl/icache_tag_lookup_random_replace_top.sv
verif/ictag_checker.sv
verif/tb.sv
